// ===== src/lir_pkg.sv =====
`timescale 1ns / 1ps

package lir_pkg;

    // Sample and position formats
    localparam int SAMPLE_BITS = 24;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int FRAC_BITS   = 16;
    localparam int INT_BITS    = 32;
    localparam int POS_BITS    = INT_BITS + FRAC_BITS;
    localparam int STEP_BITS   = 24;
    localparam int COUNT_BITS  = 32;
    localparam int PROD_BITS   = DIFF_BITS + FRAC_BITS + 2;

    // Per-request result cap and counter widths
    localparam int MAX_RESULTS  = 32;
    localparam int NRES_BITS    = $clog2(MAX_RESULTS + 1);
    localparam int DIV_CNT_BITS = $clog2(POS_BITS + 1);

    // Stream bus payload width, padded to whole bytes
    localparam int TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP          = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_LENGTH = CFG_INDEX_BITS'(1);

    // Step of 1.0 after reset
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1 << FRAC_BITS);

    // Rounding offset, half a fraction unit
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1 << (FRAC_BITS - 1));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTERP,
        ST_DIV,
        ST_HOLD,
        ST_FLUSH
    } lir_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic gen;
        logic gen_hold;
        logic div_start;
        logic skip_apply;
        logic flush_push;
        logic finish;
    } lir_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic interp_ok;
        logic skip_need;
        logic hold_ok;
        logic can_gen;
        logic pend_valid;
        logic out_free;
        logic div_busy;
        logic last_flag;
    } lir_status_t;

endpackage

// ===== src/lir_dp.sv =====
`timescale 1ns / 1ps

module lir_dp
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [lir_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [lir_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic signed [lir_pkg::SAMPLE_BITS-1:0] in_left,
    input  logic signed [lir_pkg::SAMPLE_BITS-1:0] in_right,
    input  logic                                   in_last,
    input  logic                                   out_ready,
    input  lir_pkg::lir_cmd_t                      cmd,
    output lir_pkg::lir_status_t                   st,
    output logic                                   out_valid,
    output logic signed [lir_pkg::SAMPLE_BITS-1:0] out_left,
    output logic signed [lir_pkg::SAMPLE_BITS-1:0] out_right,
    output logic                                   out_last,
    output logic                                   out_end
);

    localparam int SB = lir_pkg::SAMPLE_BITS;
    localparam int PB = lir_pkg::POS_BITS;
    localparam int TB = lir_pkg::POS_BITS + 1;
    localparam int CB = lir_pkg::COUNT_BITS;
    localparam int WB = lir_pkg::STEP_BITS;
    localparam int FB = lir_pkg::FRAC_BITS;
    localparam int XB = lir_pkg::PROD_BITS;
    localparam int DB = lir_pkg::DIFF_BITS;

    // Configuration and stream state
    logic [WB-1:0]         step_reg, step_next;
    logic [CB-1:0]         len_reg, len_next;
    logic [PB-1:0]         pos_reg, pos_next;
    logic [CB-1:0]         icnt_reg, icnt_next;
    logic [CB-1:0]         emit_reg, emit_next;
    logic                  have_prev_reg, have_prev_next;
    logic signed [SB-1:0]  prev_l_reg, prev_l_next;
    logic signed [SB-1:0]  prev_r_reg, prev_r_next;
    logic [lir_pkg::NRES_BITS-1:0] nres_reg, nres_next;
    logic                  last_reg, last_next;

    // Pending result (product stage) and output register
    logic                  pend_valid_reg, pend_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic signed [SB-1:0]  cur_l_reg, cur_l_next;
    logic signed [SB-1:0]  cur_r_reg, cur_r_next;
    logic signed [SB-1:0]  pa_l_reg, pa_l_next;
    logic signed [SB-1:0]  pa_r_reg, pa_r_next;
    logic signed [XB-1:0]  pp_l_reg, pp_l_next;
    logic signed [XB-1:0]  pp_r_reg, pp_r_next;
    logic                  pend_end_reg, pend_end_next;
    logic signed [SB-1:0]  out_l_reg, out_l_next;
    logic signed [SB-1:0]  out_r_reg, out_r_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_end_reg, out_end_next;

    // Skip divider
    logic                  div_busy_reg, div_busy_next;
    logic [lir_pkg::DIV_CNT_BITS-1:0] div_cnt_reg, div_cnt_next;
    logic [PB-1:0]         div_quo_reg, div_quo_next;
    logic [WB-1:0]         div_rem_reg, div_rem_next;

    // Combinational terms
    logic [WB-1:0]         stp;
    logic [lir_pkg::INT_BITS-1:0] pos_int;
    logic [FB-1:0]         frac;
    logic [CB-1:0]         idx_lim;
    logic                  pos_in, emit_room, cap_room, out_free, push;
    logic signed [DB-1:0]  diff_l, diff_r;
    logic signed [FB:0]    frac_s;
    logic signed [XB-1:0]  prod_l, prod_r, rnd_l, rnd_r;
    logic [TB-1:0]         target, dividend, skip, new_pos;
    logic [CB-1:0]         room;
    logic [WB:0]           rem_sh, rem_sub;

    // Interval and cap checks
    always_comb
    begin
        stp       = (step_reg == '0) ? WB'(1) : step_reg;
        pos_int   = pos_reg[PB-1:FB];
        frac      = pos_reg[FB-1:0];
        idx_lim   = icnt_reg - CB'(1);
        pos_in    = pos_int <= idx_lim;
        emit_room = emit_reg < len_reg;
        cap_room  = nres_reg < lir_pkg::NRES_BITS'(lir_pkg::MAX_RESULTS);
        out_free  = !out_valid_reg || out_ready;

        st.interp_ok  = have_prev_reg && cap_room && emit_room && pos_in;
        st.skip_need  = have_prev_reg && emit_room && pos_in;
        st.hold_ok    = cap_room && emit_room;
        st.can_gen    = !pend_valid_reg || out_free;
        st.pend_valid = pend_valid_reg;
        st.out_free   = out_free;
        st.div_busy   = div_busy_reg;
        st.last_flag  = last_reg;
    end

    // Blend products, rounding and skip arithmetic
    always_comb
    begin
        diff_l  = DB'(cur_l_reg) - DB'(prev_l_reg);
        diff_r  = DB'(cur_r_reg) - DB'(prev_r_reg);
        frac_s  = $signed({1'b0, frac});
        prod_l  = XB'(diff_l) * XB'(frac_s);
        prod_r  = XB'(diff_r) * XB'(frac_s);
        rnd_l   = (pp_l_reg + lir_pkg::ROUND_HALF) >>> FB;
        rnd_r   = (pp_r_reg + lir_pkg::ROUND_HALF) >>> FB;

        // end of the current interval; a zero count means 2^32
        target   = {(icnt_reg == '0), icnt_reg, {FB{1'b0}}};
        dividend = target - TB'(pos_reg) - TB'(1);
        skip     = TB'(div_quo_reg) + TB'(1);
        room     = len_reg - emit_reg;
        new_pos  = target - TB'(1) - TB'(div_rem_reg) + TB'(stp);

        rem_sh   = {div_rem_reg, div_quo_reg[PB-1]};
        rem_sub  = rem_sh - (WB + 1)'(stp);
    end

    assign push = (cmd.gen && pend_valid_reg) || cmd.flush_push;

    // Next-state logic
    always_comb
    begin
        step_next       = step_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        icnt_next       = icnt_reg;
        emit_next       = emit_reg;
        have_prev_next  = have_prev_reg;
        prev_l_next     = prev_l_reg;
        prev_r_next     = prev_r_reg;
        nres_next       = nres_reg;
        last_next       = last_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        cur_l_next      = cur_l_reg;
        cur_r_next      = cur_r_reg;
        pa_l_next       = pa_l_reg;
        pa_r_next       = pa_r_reg;
        pp_l_next       = pp_l_reg;
        pp_r_next       = pp_r_reg;
        pend_end_next   = pend_end_reg;
        out_l_next      = out_l_reg;
        out_r_next      = out_r_reg;
        out_last_next   = out_last_reg;
        out_end_next    = out_end_reg;
        div_busy_next   = div_busy_reg;
        div_cnt_next    = div_cnt_reg;
        div_quo_next    = div_quo_reg;
        div_rem_next    = div_rem_reg;

        // register writes
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lir_pkg::REG_STEP:          step_next = cfg_data[WB-1:0];
                lir_pkg::REG_OUTPUT_LENGTH: len_next  = cfg_data[CB-1:0];
                default:                    ;
            endcase
        end

        // take a new frame
        if (cmd.capture)
        begin
            cur_l_next = in_left;
            cur_r_next = in_right;
            last_next  = in_last;
            nres_next  = '0;
        end

        // output register
        if (push)
        begin
            out_valid_next = 1'b1;
            out_l_next     = pa_l_reg + rnd_l[SB-1:0];
            out_r_next     = pa_r_reg + rnd_r[SB-1:0];
            out_last_next  = cmd.flush_push;
            out_end_next   = pend_end_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // generate one result into the pending stage
        if (cmd.gen)
        begin
            pend_valid_next = 1'b1;
            pa_l_next       = cmd.gen_hold ? cur_l_reg : prev_l_reg;
            pa_r_next       = cmd.gen_hold ? cur_r_reg : prev_r_reg;
            pp_l_next       = cmd.gen_hold ? '0 : prod_l;
            pp_r_next       = cmd.gen_hold ? '0 : prod_r;
            pend_end_next   = (emit_reg + CB'(1)) == len_reg;
            emit_next       = emit_reg + CB'(1);
            nres_next       = nres_reg + lir_pkg::NRES_BITS'(1);
            if (!cmd.gen_hold)
            begin
                pos_next = pos_reg + PB'(stp);
            end
        end
        else if (cmd.flush_push)
        begin
            pend_valid_next = 1'b0;
        end

        // restoring divider for the skipped positions, one bit a cycle
        if (cmd.div_start)
        begin
            div_busy_next = 1'b1;
            div_cnt_next  = lir_pkg::DIV_CNT_BITS'(PB);
            div_quo_next  = dividend[PB-1:0];
            div_rem_next  = '0;
        end
        else if (div_busy_reg)
        begin
            if (!rem_sub[WB])
            begin
                div_rem_next = rem_sub[WB-1:0];
                div_quo_next = {div_quo_reg[PB-2:0], 1'b1};
            end
            else
            begin
                div_rem_next = rem_sh[WB-1:0];
                div_quo_next = {div_quo_reg[PB-2:0], 1'b0};
            end
            div_cnt_next = div_cnt_reg - lir_pkg::DIV_CNT_BITS'(1);
            if (div_cnt_reg == lir_pkg::DIV_CNT_BITS'(1))
            begin
                div_busy_next = 1'b0;
            end
        end

        // step over the dropped positions
        if (cmd.skip_apply)
        begin
            emit_next = (skip >= TB'(room)) ? len_reg : emit_reg + skip[CB-1:0];
            pos_next  = new_pos[PB-1:0];
        end

        // close the request: end of stream clears, otherwise keep the frame
        if (cmd.finish)
        begin
            if (last_reg)
            begin
                prev_l_next    = '0;
                prev_r_next    = '0;
                pos_next       = '0;
                icnt_next      = '0;
                emit_next      = '0;
                have_prev_next = 1'b0;
            end
            else
            begin
                prev_l_next    = cur_l_reg;
                prev_r_next    = cur_r_reg;
                have_prev_next = 1'b1;
                icnt_next      = icnt_reg + CB'(1);
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= lir_pkg::STEP_RESET;
            len_reg        <= '0;
            pos_reg        <= '0;
            icnt_reg       <= '0;
            emit_reg       <= '0;
            have_prev_reg  <= 1'b0;
            prev_l_reg     <= '0;
            prev_r_reg     <= '0;
            nres_reg       <= '0;
            last_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            div_busy_reg   <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            step_reg       <= step_next;
            len_reg        <= len_next;
            pos_reg        <= pos_next;
            icnt_reg       <= icnt_next;
            emit_reg       <= emit_next;
            have_prev_reg  <= have_prev_next;
            prev_l_reg     <= prev_l_next;
            prev_r_reg     <= prev_r_next;
            nres_reg       <= nres_next;
            last_reg       <= last_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            div_busy_reg   <= div_busy_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_l_reg    <= cur_l_next;
        cur_r_reg    <= cur_r_next;
        pa_l_reg     <= pa_l_next;
        pa_r_reg     <= pa_r_next;
        pp_l_reg     <= pp_l_next;
        pp_r_reg     <= pp_r_next;
        pend_end_reg <= pend_end_next;
        out_l_reg    <= out_l_next;
        out_r_reg    <= out_r_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
        div_quo_reg  <= div_quo_next;
        div_rem_reg  <= div_rem_next;
    end

    assign out_valid = out_valid_reg;
    assign out_left  = out_l_reg;
    assign out_right = out_r_reg;
    assign out_last  = out_last_reg;
    assign out_end   = out_end_reg;

endmodule

// ===== src/lir_ctrl.sv =====
`timescale 1ns / 1ps

module lir_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lir_pkg::lir_status_t st,
    output lir_pkg::lir_cmd_t    cmd
);

    lir_pkg::lir_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lir_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lir_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lir_pkg::ST_INTERP;
                end
            end
            lir_pkg::ST_INTERP:
            begin
                if (!st.interp_ok)
                begin
                    if (st.last_flag)
                    begin
                        state_next = lir_pkg::ST_HOLD;
                    end
                    else if (st.skip_need)
                    begin
                        state_next = lir_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = lir_pkg::ST_FLUSH;
                    end
                end
            end
            lir_pkg::ST_DIV:
            begin
                if (!st.div_busy)
                begin
                    state_next = lir_pkg::ST_FLUSH;
                end
            end
            lir_pkg::ST_HOLD:
            begin
                if (!st.hold_ok)
                begin
                    state_next = lir_pkg::ST_FLUSH;
                end
            end
            lir_pkg::ST_FLUSH:
            begin
                if (!st.pend_valid || st.out_free)
                begin
                    state_next = lir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lir_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            lir_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            lir_pkg::ST_INTERP:
            begin
                if (st.interp_ok)
                begin
                    cmd.gen = st.can_gen;
                end
                else if (!st.last_flag && st.skip_need)
                begin
                    cmd.div_start = 1'b1;
                end
            end
            lir_pkg::ST_DIV:
            begin
                cmd.skip_apply = !st.div_busy;
            end
            lir_pkg::ST_HOLD:
            begin
                cmd.gen_hold = 1'b1;
                cmd.gen      = st.hold_ok && st.can_gen;
            end
            lir_pkg::ST_FLUSH:
            begin
                if (!st.pend_valid)
                begin
                    cmd.finish = 1'b1;
                end
                else if (st.out_free)
                begin
                    cmd.flush_push = 1'b1;
                    cmd.finish     = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/linear_interp_resampler.sv =====
`timescale 1ns / 1ps

// Stereo linear-interpolation resampler.
// Input stream: one request is one stereo frame, tlast marks the final frame.
// Output stream: resampled frames; tlast marks the last frame produced by one
// input request, tuser marks the frame that completes output_length.
// Configuration (step, output_length) is to be written only while the block
// is idle; the user is bound by this, the block itself does not enforce it.
// Timing: a frame is taken in the idle state; each result then takes one
// cycle of the interpolation loop while the pending stage can advance, and
// passes the pending stage into the output register. The next frame is taken
// once the request ends, after the hold results for a final frame.
// When more than 32 positions fall in one interval of a non-final frame, the
// dropped positions are counted by a one-bit-a-cycle divider in that request.
// Reset restores step 1.0, output_length 0 and clears all stream state.
// A receiver stall holds the output register; the loop then pauses once a
// second result waits in the pending stage, and resumes when it drains.

module linear_interp_resampler
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [lir_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [lir_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lir_pkg::TDATA_BITS-1:0]        s_tdata,   // left_sample, right_sample
    input  logic                                  s_tlast,   // last_in
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lir_pkg::TDATA_BITS-1:0]        m_tdata,   // left_out, right_out
    output logic                                  m_tlast,   // last_out
    output logic                                  m_tuser    // stream_end
);

    localparam int SB = lir_pkg::SAMPLE_BITS;

    lir_pkg::lir_cmd_t    cmd;
    lir_pkg::lir_status_t st;
    logic signed [SB-1:0] out_left, out_right;

    lir_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lir_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_left   ($signed(s_tdata[SB-1:0])),
        .in_right  ($signed(s_tdata[2*SB-1:SB])),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .cmd       (cmd),
        .st        (st),
        .out_valid (m_tvalid),
        .out_left  (out_left),
        .out_right (out_right),
        .out_last  (m_tlast),
        .out_end   (m_tuser)
    );

    // Pack output payload, zero padding on top
    assign m_tdata = lir_pkg::TDATA_BITS'({out_right, out_left});

`ifndef ASSERT_OFF
    // Nothing may be left in the pending stage once a new frame is taken
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !st.pend_valid)
        else $error("pending result left over when input is ready");

    // One frame at a time
    a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready straight after a request");

    // The divider only runs inside a request
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st.div_busy |-> !s_tready)
        else $error("input ready while skip divider is busy");

    // Results are never generated outside a request
    a_gen_in_request: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gen |-> !s_tready && !cmd.finish)
        else $error("result generated outside a request");
`endif

endmodule

// ===== bench/tb_linear_interp_resampler.sv =====
`timescale 1ns / 1ps

module tb_linear_interp_resampler;

    localparam int SB          = lir_pkg::SAMPLE_BITS;
    localparam int FB          = lir_pkg::FRAC_BITS;
    localparam int PB          = lir_pkg::POS_BITS;
    localparam int RESULT_CAP  = lir_pkg::MAX_RESULTS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RX_HOLD_CYCLES = 400;
    // covers the skip divider plus a full batch of results
    localparam int SETTLE_CYCLES  = 200;
    localparam int RANDOM_FRAMES  = 500;
    localparam int MAX_REPORTS    = 100;

    typedef struct packed {
        logic [SB-1:0] left;
        logic [SB-1:0] right;
        logic          fin;
    } stereo_in_t;

    typedef struct packed {
        logic [SB-1:0] left;
        logic [SB-1:0] right;
        logic          last_frame;
        logic          stream_end;
    } resampled_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [lir_pkg::CFG_INDEX_BITS-1:0] cfg_index = lir_pkg::REG_STEP;
    logic [lir_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [lir_pkg::TDATA_BITS-1:0] s_tdata = '0;   // left_sample, right_sample
    logic s_tlast = 1'b0;                             // last_in
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [lir_pkg::TDATA_BITS-1:0] m_tdata;          // left_out, right_out
    logic m_tlast;                                    // last_out
    logic m_tuser;                                    // stream_end

    // Stimulus queue and expected output frames
    stereo_in_t tx_frames[$];
    stereo_in_t tx_next;
    resampled_t due_frames[$];
    resampled_t want_frame;

    // Resampler mirror: registers and stream state
    logic [23:0]   cfg_step = lir_pkg::STEP_RESET;
    logic [31:0]   cfg_out_len = '0;
    logic [SB-1:0] held_left = '0;
    logic [SB-1:0] held_right = '0;
    logic [PB-1:0] src_pos = '0;
    logic [31:0]   frames_in = '0;
    logic [31:0]   frames_out = '0;
    logic          have_held = 1'b0;

    // Idling and hold-off control
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_asked = 0;
    int rx_hold_given = 0;
    int rx_hold_left = 0;

    int n_errors = 0;
    int requests_in = 0;
    int frames_checked = 0;
    int streams_sent = 0;
    int cycle_count = 0;

    linear_interp_resampler i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    // a + round(f * (b - a) / 2^FB), halves towards plus infinity
    function automatic logic [SB-1:0] blend_sample(logic [SB-1:0] a, logic [SB-1:0] b,
                                                   logic [FB-1:0] f);
        longint sa;
        longint prod;
        sa = longint'($signed(a));
        prod = (longint'($signed(b)) - sa) * longint'({1'b0, f})
               + (longint'(1) << (FB - 1));
        return SB'(sa + (prod >>> FB));
    endfunction

    // one output frame; bumps the output count and flags the stream end
    function automatic resampled_t count_frame(logic [SB-1:0] l, logic [SB-1:0] r);
        resampled_t fr;
        frames_out = frames_out + 32'd1;
        fr.left = l;
        fr.right = r;
        fr.last_frame = 1'b0;
        fr.stream_end = (frames_out == cfg_out_len);
        return fr;
    endfunction

    // Output frames caused by one accepted input frame
    task automatic predict_frames(input logic [SB-1:0] cur_l, input logic [SB-1:0] cur_r,
                                  input logic fin);
        resampled_t batch[$];
        logic [63:0] stp;
        logic [63:0] target;
        logic [63:0] skip;
        logic [31:0] idx_lim;
        stp = (cfg_step == '0) ? 64'd1 : 64'(cfg_step);
        if (have_held)
        begin
            idx_lim = frames_in - 32'd1;
            while (batch.size() < RESULT_CAP && frames_out < cfg_out_len &&
                   src_pos[PB-1:FB] <= idx_lim)
            begin
                batch.push_back(count_frame(blend_sample(held_left, cur_l, src_pos[FB-1:0]),
                                            blend_sample(held_right, cur_r, src_pos[FB-1:0])));
                src_pos = src_pos + PB'(stp);
            end
            // positions beyond the cap are dropped but still counted
            if (!fin && frames_out < cfg_out_len && src_pos[PB-1:FB] <= idx_lim)
            begin
                target = (64'(idx_lim) + 64'd1) << FB;
                skip = (target - 64'(src_pos) + stp - 64'd1) / stp;
                if (skip >= 64'(cfg_out_len - frames_out))
                    frames_out = cfg_out_len;
                else
                    frames_out = frames_out + skip[31:0];
                src_pos = src_pos + PB'(skip * stp);
            end
        end
        if (fin)
        begin
            // hold the final frame up to the cap, then back to a fresh stream
            while (batch.size() < RESULT_CAP && frames_out < cfg_out_len)
                batch.push_back(count_frame(cur_l, cur_r));
            held_left = '0;
            held_right = '0;
            src_pos = '0;
            frames_in = '0;
            frames_out = '0;
            have_held = 1'b0;
        end
        else
        begin
            held_left = cur_l;
            held_right = cur_r;
            have_held = 1'b1;
            frames_in = frames_in + 32'd1;
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last_frame = 1'b1;
        foreach (batch[k])
            due_frames.push_back(batch[k]);
    endtask

    // Input driver; prediction happens on each accepted request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_frames(s_tdata[SB-1:0], s_tdata[2*SB-1:SB], s_tlast);
                requests_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_frames.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    tx_next = tx_frames.pop_front();
                    s_tdata <= {tx_next.right, tx_next.left};
                    s_tlast <= tx_next.fin;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_frames.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display({"%0t: unexpected frame: expected none, ",
                                  "got L=%h R=%h last=%b end=%b"},
                                 $time, m_tdata[SB-1:0], m_tdata[2*SB-1:SB], m_tlast, m_tuser);
                end
                else
                begin
                    want_frame = due_frames.pop_front();
                    if (m_tdata[SB-1:0] !== want_frame.left ||
                        m_tdata[2*SB-1:SB] !== want_frame.right ||
                        m_tlast !== want_frame.last_frame ||
                        m_tuser !== want_frame.stream_end)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display({"%0t: frame %0d: expected L=%h R=%h last=%b end=%b, ",
                                      "got L=%h R=%h last=%b end=%b"},
                                     $time, frames_checked, want_frame.left, want_frame.right,
                                     want_frame.last_frame, want_frame.stream_end,
                                     m_tdata[SB-1:0], m_tdata[2*SB-1:SB], m_tlast, m_tuser);
                    end
                    frames_checked++;
                end
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left <= rx_hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (rx_hold_asked != rx_hold_given)
            begin
                rx_hold_given <= rx_hold_asked;
                rx_hold_left <= RX_HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d frames still expected", $time, due_frames.size());
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return SB'($urandom);
        endcase
    endfunction

    task automatic queue_frame(input logic [SB-1:0] l, input logic [SB-1:0] r,
                               input logic fin);
        stereo_in_t fr;
        fr.left = l;
        fr.right = r;
        fr.fin = fin;
        tx_frames.push_back(fr);
    endtask

    // wait until every request is taken and every output has arrived
    task automatic wait_drained();
        while (!(tx_frames.size() == 0 && !s_tvalid && due_frames.size() == 0))
            @(posedge clk);
    endtask

    // idle block, then new register values
    task automatic configure(input logic [23:0] stp, input logic [31:0] len);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= lir_pkg::REG_STEP;
        cfg_data <= 32'(stp);
        cfg_step = stp;
        @(posedge clk);
        cfg_index <= lir_pkg::REG_OUTPUT_LENGTH;
        cfg_data <= len;
        cfg_out_len = len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // random stream of n frames, optionally pausing the sender after 'split'
    task automatic queue_stream(input int n, input int split);
        for (int k = 0; k < n; k++)
        begin
            if (split > 0 && k == split)
                wait_drained();
            queue_frame(pick_sample(), pick_sample(), k == n - 1);
        end
        streams_sent++;
    endtask

    initial
    begin
        int n;
        int rand_frames;
        int stream_no;
        int split;
        logic [23:0] stp;
        logic [31:0] len;
        longint unsigned eff;
        longint unsigned nominal;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: pass-through at 1.0 with full-scale samples
        configure(24'h010000, 32'd6);
        queue_frame(24'h7FFFFF, 24'h800000, 1'b0);
        queue_frame(24'h800000, 24'h7FFFFF, 1'b0);
        queue_frame(24'h000000, 24'hFFFFFF, 1'b0);
        queue_frame(24'hFFFFFF, 24'h000001, 1'b0);
        queue_frame(24'h7FFFFF, 24'h7FFFFF, 1'b0);
        queue_frame(24'h800000, 24'h800000, 1'b1);
        streams_sent++;

        // smallest nominal step, full swings and rounding of halves
        configure(24'd4096, 32'd40);
        queue_frame(24'h800000, 24'h7FFFFF, 1'b0);
        queue_frame(24'h7FFFFF, 24'h800000, 1'b0);
        queue_frame(24'h000001, 24'hFFFFFF, 1'b0);
        queue_frame(24'h123456, 24'hEDCBA9, 1'b1);
        streams_sent++;

        // zero step: result cap, dropped positions, capped tail, max count
        configure(24'd0, 32'hFFFFFFFF);
        queue_stream(3, 0);

        // largest step: requests with no output at all
        configure(24'hFFFFFF, 32'd3);
        queue_stream(5, 0);

        // first frame is also the last: hold outputs only
        configure(24'd98304, 32'd2);
        queue_frame(24'h400000, 24'hC00000, 1'b1);
        streams_sent++;

        // output count reached inside the first interval
        configure(24'd4096, 32'd2);
        queue_stream(3, 0);

        // Random streams
        rand_frames = 0;
        stream_no = 0;
        while (rand_frames < RANDOM_FRAMES)
        begin
            if (rand_frames < RANDOM_FRAMES / 3)
            begin
                tx_idle_pct = 14;
                rx_idle_pct = 48;
            end
            else if (rand_frames < 2 * RANDOM_FRAMES / 3)
            begin
                tx_idle_pct = 48;
                rx_idle_pct = 14;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            case ($urandom_range(0, 9))
                0: n = 1;
                1, 2: n = $urandom_range(25, 60);
                default: n = $urandom_range(2, 24);
            endcase

            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: stp = 24'($urandom_range(4096, 65535));
                6, 7, 8, 9, 10, 11: stp = 24'($urandom_range(65536, 200000));
                12, 13: stp = 24'($urandom_range(200001, 16777215));
                14: stp = 24'd4096;
                15: stp = 24'hFFFFFF;
                16: stp = 24'h010000;
                17: stp = 24'($urandom_range(0, 4095));
                18: stp = 24'($urandom);
                default: stp = 24'd0;
            endcase

            // a stream rich in output to fill the block under a long hold-off
            if (stream_no == 2)
            begin
                stp = 24'd4096;
                n = 30;
            end

            eff = (stp == '0) ? 64'd1 : 64'(stp);
            nominal = (64'(n) * 64'd65536 + eff / 2) / eff;
            case ($urandom_range(0, 19))
                0, 1: len = 32'(nominal) + 32'($urandom_range(1, 40));
                2: len = 32'd0;
                3: len = 32'hFFFFFFFF;
                4: len = $urandom;
                default: len = 32'(nominal);
            endcase

            // the hold-off stream needs its full output count
            if (stream_no == 2)
                len = 32'(nominal);

            configure(stp, len);
            split = (stream_no == 4 || stream_no == 11) ? n / 2 : 0;
            if (stream_no == 2)
                rx_hold_asked++;
            queue_stream(n, split);
            rand_frames += n;
            stream_no++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d requests in %0d streams, %0d output frames checked",
                 requests_in, streams_sent, frames_checked);
        $display({"summary: steps zero to full scale, output counts zero to maximum, ",
                  "with hold-off and drain pauses"});
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
src/lir_pkg.sv
src/lir_dp.sv
src/lir_ctrl.sv
src/linear_interp_resampler.sv
bench/tb_linear_interp_resampler.sv
